// File: hw/rtl/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types, sizes and codes for the bounded deque engine.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int DEPTH      = 16;                       // ring slots
  localparam int DATA_WIDTH = 32;                       // stored word width
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int COUNT_W    = 5;                        // entry_count field width
  localparam int POS_W      = 8;                        // position field width
  localparam int IDX_W      = POS_W + 1;                // slot sum before wrap
  localparam int WORD_W     = 32;                       // push_data / result_data width

  // Command queue between front and back; must be at least two entries.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int REG_IDX_W = 1;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;
  localparam logic [COUNT_W-1:0]   CAP_RESET    = COUNT_W'(16);

  typedef enum logic [1:0] {
    REQ_PUSH_TAIL = 2'd0,
    REQ_PUSH_HEAD = 2'd1,
    REQ_POP_HEAD  = 2'd2,
    REQ_READ_POS  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One classified request, ready for the slot store.
  typedef struct packed {
    logic                  is_write;
    logic                  is_read;
    logic [SLOT_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] wdata;
    status_t               status;
    logic [COUNT_W-1:0]    count;
  } cmd_t;

endpackage

// File: hw/rtl/bde_ram.sv
// ----------------------------------------------------------------------------
// bde_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bde_front.sv
// ----------------------------------------------------------------------------
// bde_front
// Accepts requests, keeps the ring pointer, count and capacity register, and
// turns each request into a slot-store command with its final status.
// ----------------------------------------------------------------------------
module bde_front import bde_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [WORD_W-1:0]   push_data,
  input  logic [POS_W-1:0]    position,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                q_full,
  output logic                cmd_push,
  output cmd_t                cmd
);

  logic [SLOT_W-1:0]  front_index, front_index_next;
  logic [COUNT_W-1:0] held_count, held_count_next;
  logic [COUNT_W-1:0] capacity_limit;
  logic [COUNT_W-1:0] limit;
  logic               full_now;
  logic [SLOT_W-1:0]  tail_slot, read_slot, head_prev, head_after;
  logic               accept;
  logic               cfg_write;

  function automatic logic [SLOT_W-1:0] ring_wrap(input logic [IDX_W-1:0] s);
    // Sums whose slot is used stay below twice the ring size.
    if (s >= IDX_W'(DEPTH)) begin
      ring_wrap = SLOT_W'(s - IDX_W'(DEPTH));
    end else begin
      ring_wrap = SLOT_W'(s);
    end
  endfunction

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign prdata    = (paddr[ADDR_W-1:2] == REG_CAPACITY) ?
                     PDATA_W'(capacity_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_write) begin
      capacity_limit <= pwdata[COUNT_W-1:0];
    end
  end

  assign limit    = (capacity_limit > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : capacity_limit;
  assign full_now = (held_count >= limit);

  assign tail_slot  = ring_wrap(IDX_W'(front_index) + IDX_W'(held_count));
  assign read_slot  = ring_wrap(IDX_W'(front_index) + IDX_W'(position));
  assign head_prev  = (front_index == '0) ? SLOT_W'(DEPTH - 1) : front_index - SLOT_W'(1);
  assign head_after = (front_index == SLOT_W'(DEPTH - 1)) ? '0 : front_index + SLOT_W'(1);

  always_comb begin
    front_index_next = front_index;
    held_count_next  = held_count;
    cmd.is_write     = 1'b0;
    cmd.is_read      = 1'b0;
    cmd.addr         = front_index;
    cmd.wdata        = DATA_WIDTH'(push_data);
    cmd.status       = ST_OK;
    case (req_t'(req_type))
      REQ_PUSH_TAIL: begin
        if (full_now) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.is_write    = 1'b1;
          cmd.addr        = tail_slot;
          held_count_next = held_count + COUNT_W'(1);
        end
      end
      REQ_PUSH_HEAD: begin
        if (full_now) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.is_write     = 1'b1;
          cmd.addr         = head_prev;
          front_index_next = head_prev;
          held_count_next  = held_count + COUNT_W'(1);
        end
      end
      REQ_POP_HEAD: begin
        if (held_count == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.is_read      = 1'b1;
          front_index_next = head_after;
          held_count_next  = held_count - COUNT_W'(1);
        end
      end
      REQ_READ_POS: begin
        if (IDX_W'(position) >= IDX_W'(held_count)) begin
          cmd.status = ST_NOT_FOUND;
        end else begin
          cmd.is_read = 1'b1;
          cmd.addr    = read_slot;
        end
      end
      default: begin
        cmd.status = ST_NOT_FOUND;
      end
    endcase
    cmd.count = held_count_next;
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign cmd_push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      held_count  <= '0;
    end else if (accept) begin
      front_index <= front_index_next;
      held_count  <= held_count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(DEPTH))
    else $error("entry count exceeds ring size");

  a_fail_keeps_state: assert property (@(posedge clk) disable iff (rst)
    cmd_push && (cmd.status != ST_OK) |=> $stable(held_count) && $stable(front_index))
    else $error("failed request changed the ring state");
`endif

endmodule

// File: hw/rtl/bde_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bde_cmd_fifo
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module bde_cmd_fifo import bde_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = (fill == QCNT_W'(QDEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hw/rtl/bde_back.sv
// ----------------------------------------------------------------------------
// bde_back
// Carries out queued commands on the slot store and holds the result item
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module bde_back import bde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [WORD_W-1:0]  result_data,
  output logic [COUNT_W-1:0] entry_count
);

  logic                  s1_valid;
  logic                  s1_read;
  status_t               s1_status;
  logic [COUNT_W-1:0]    s1_count;
  logic                  s1_adv;
  logic                  issue;
  logic [DATA_WIDTH-1:0] rdata;

  // The output register frees up when it is empty or being taken.
  assign s1_adv = s1_valid && (!out_valid || !out_stall);
  assign issue  = q_valid && (!s1_valid || s1_adv);
  assign q_pop  = issue;

  bde_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (issue && q_cmd.is_write),
    .waddr (q_cmd.addr),
    .wdata (q_cmd.wdata),
    .re    (issue && q_cmd.is_read),
    .raddr (q_cmd.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_read   <= q_cmd.is_read;
      s1_status <= q_cmd.status;
      s1_count  <= q_cmd.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The read data stays put while a read waits in s1, since nothing issues.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status      <= s1_status;
      result_data <= s1_read ? WORD_W'(rdata) : '0;
      entry_count <= s1_count;
    end
  end

`ifndef SYNTHESIS
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (result_data == '0))
    else $error("failed request carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with nonzero count");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && $stable(s1_count))
    else $error("stage one lost a command under stall");
`endif

endmodule

// File: hw/rtl/bounded_deque_engine.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of data words held in a ring of slots.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  request  | in_valid / in_stall      | req_type, push_data, position
//  result   | out_valid / out_stall    | status, result_data, entry_count
//  config   | psel penable pwrite ...  | paddr, pwdata, prdata (capacity)
//
// One item is accepted per cycle while the command queue is not full; its
// result passes the command queue, the RAM read stage and the output register.
// Reset clears the ring pointer and count and sets the capacity to 16; the
// slot RAM is not cleared. The front stalls only when the command queue is
// full, so a held result stalls input after the queue fills.
// ----------------------------------------------------------------------------
module bounded_deque_engine import bde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [WORD_W-1:0]  push_data,
  input  logic [POS_W-1:0]   position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [WORD_W-1:0]  result_data,
  output logic [COUNT_W-1:0] entry_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  bde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .push_data (push_data),
    .position  (position),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  bde_cmd_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  bde_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .result_data (result_data),
    .entry_count (entry_count)
  );

endmodule

// File: sim/bounded_deque_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_engine_test
// Self-checking bench for the bounded deque engine. A short table of directed
// requests exercises empty, full and out-of-range cases and capacity changes.
// Random traffic in several phases then alternates between filling and
// draining the ring under varied sender gaps, receiver stalls and two long
// receiver hold-offs. Each result is checked against its typed row or a behavioral deque.
// ----------------------------------------------------------------------------
module bounded_deque_engine_test;
  import bde_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES  = 80;
  localparam int NUM_PHASES   = 8;
  localparam int PRESSURE_PHASE = 4;
  localparam int MAX_PRINTS   = 50;
  localparam logic [ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);

  typedef struct packed {
    status_t            st;
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } deque_result_t;

  typedef struct packed {
    logic               cfg;
    logic [ADDR_W-1:0]  cfg_addr;
    logic [PDATA_W-1:0] cfg_val;
    req_t               req;
    logic [WORD_W-1:0]  word;
    logic [POS_W-1:0]   pos;
    logic               typed;
    deque_result_t      want;
  } step_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = '0;
  logic [WORD_W-1:0]  push_data = '0;
  logic [POS_W-1:0]   position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [WORD_W-1:0]  result_data;
  logic [COUNT_W-1:0] entry_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bounded_deque_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .push_data(push_data), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_data(result_data), .entry_count(entry_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Behavioral copy of the deque.
  logic [WORD_W-1:0]  ring_words [DEPTH];
  logic [SLOT_W-1:0]  head_slot = '0;
  int                 held_entries = 0;
  logic [COUNT_W-1:0] capacity_now = CAP_RESET;

  deque_result_t pending_results [$];
  step_row_t     directed_rows [$];
  deque_result_t oldest;
  int            mismatches = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            hold_request = 1'b0;
  int            hold_left = 0;

  int phase_items [NUM_PHASES] = '{300, 300, 300, 300, 200, 50, 300, 200};
  int phase_cap   [NUM_PHASES] = '{16, 31, 9, 16, 16, 0, -1, 16};
  int phase_idle  [NUM_PHASES] = '{0, 46, 0, 19, 0, 19, 19, 0};
  int phase_stall [NUM_PHASES] = '{0, 0, 46, 19, 0, 19, 19, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bounded_deque_engine test failed");
      $finish;
    end
  end

  function automatic deque_result_t apply_request(req_t r, logic [WORD_W-1:0] w,
                                                  logic [POS_W-1:0] p);
    deque_result_t res;
    int            lim;
    lim = (capacity_now > DEPTH) ? DEPTH : int'(capacity_now);
    res.st = ST_OK;
    res.data = '0;
    case (r)
      REQ_PUSH_TAIL: begin
        if (held_entries >= lim) res.st = ST_FULL;
        else begin
          ring_words[SLOT_W'(head_slot + held_entries)] = w;
          held_entries++;
        end
      end
      REQ_PUSH_HEAD: begin
        if (held_entries >= lim) res.st = ST_FULL;
        else begin
          head_slot = head_slot - 1'b1;
          ring_words[head_slot] = w;
          held_entries++;
        end
      end
      REQ_POP_HEAD: begin
        if (held_entries == 0) res.st = ST_EMPTY;
        else begin
          res.data = ring_words[head_slot];
          head_slot = head_slot + 1'b1;
          held_entries--;
        end
      end
      default: begin
        if (int'(p) >= held_entries) res.st = ST_NOT_FOUND;
        else res.data = ring_words[SLOT_W'(head_slot + p)];
      end
    endcase
    res.count = COUNT_W'(held_entries);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // The bench only ever reads the pre-edge values of the block's outputs.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", result_data, '0);
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.st)
          report_mismatch("status", WORD_W'(status), WORD_W'(oldest.st));
        if (result_data !== oldest.data)
          report_mismatch("result_data", result_data, oldest.data);
        if (entry_count !== oldest.count)
          report_mismatch("entry_count", WORD_W'(entry_count), WORD_W'(oldest.count));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic put_row(logic cfg, logic [ADDR_W-1:0] a, logic [PDATA_W-1:0] v,
                         req_t r, logic [WORD_W-1:0] w, logic [POS_W-1:0] p,
                         logic typed, status_t st, logic [WORD_W-1:0] d,
                         logic [COUNT_W-1:0] c);
    step_row_t row;
    row.cfg = cfg;
    row.cfg_addr = a;
    row.cfg_val = v;
    row.req = r;
    row.word = w;
    row.pos = p;
    row.typed = typed;
    row.want.st = st;
    row.want.data = d;
    row.want.count = c;
    directed_rows.push_back(row);
  endtask

  task automatic offer_item(req_t r, logic [WORD_W-1:0] w, logic [POS_W-1:0] p,
                            logic typed, deque_result_t want);
    deque_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    push_data <= w;
    position <= p;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(r, w, p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [ADDR_W-1:0] a, logic [PDATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // Only the capacity register exists; other indexes are ignored.
    if (a[ADDR_W-1:2] == REG_CAPACITY) capacity_now = v[COUNT_W-1:0];
  endtask

  initial begin
    int            ph;
    int            k;
    int            pick;
    int            cap;
    bit            filling;
    req_t          r;
    logic [POS_W-1:0] p;
    deque_result_t none;

    none = '0;
    filling = 1'b0;

    // cfg addr val      | request        word          pos | typed expectation
    put_row(0, 0, 0,       REQ_POP_HEAD,  0,            0,   1, ST_EMPTY, 0, 0);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            0,   1, ST_NOT_FOUND, 0, 0);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            255, 1, ST_NOT_FOUND, 0, 0);
    put_row(0, 0, 0,       REQ_PUSH_TAIL, 32'hFFFFFFFF, 0,   1, ST_OK, 0, 1);
    put_row(0, 0, 0,       REQ_PUSH_HEAD, 32'h00000000, 255, 1, ST_OK, 0, 2);
    put_row(0, 0, 0,       REQ_PUSH_TAIL, 32'hA5A5A5A5, 0,   1, ST_OK, 0, 3);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            0,   0, ST_OK, 0, 0);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            2,   0, ST_OK, 0, 0);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            3,   1, ST_NOT_FOUND, 0, 3);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            255, 1, ST_NOT_FOUND, 0, 3);
    put_row(0, 0, 0,       REQ_POP_HEAD,  0,            0,   0, ST_OK, 0, 0);
    put_row(0, 0, 0,       REQ_POP_HEAD,  0,            0,   0, ST_OK, 0, 0);
    put_row(0, 0, 0,       REQ_POP_HEAD,  0,            0,   0, ST_OK, 0, 0);
    put_row(0, 0, 0,       REQ_POP_HEAD,  0,            0,   1, ST_EMPTY, 0, 0);
    put_row(0, 0, 0,       REQ_PUSH_HEAD, 32'h12345678, 0,   1, ST_OK, 0, 1);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            0,   0, ST_OK, 0, 0);
    put_row(0, 0, 0,       REQ_POP_HEAD,  0,            0,   0, ST_OK, 0, 0);
    put_row(1, CAP_ADDR, 0,  REQ_PUSH_TAIL, 32'h1,      0,   1, ST_FULL, 0, 0);
    put_row(0, 0, 0,       REQ_PUSH_HEAD, 32'h2,        0,   1, ST_FULL, 0, 0);
    put_row(1, CAP_ADDR, 1,  REQ_PUSH_TAIL, 32'hDEADBEEF, 0, 1, ST_OK, 0, 1);
    put_row(0, 0, 0,       REQ_PUSH_HEAD, 32'h5,        0,   1, ST_FULL, 0, 1);
    put_row(1, SPARE_ADDR, 0, REQ_PUSH_TAIL, 32'h7,     0,   1, ST_FULL, 0, 1);
    put_row(1, CAP_ADDR, 31, REQ_PUSH_HEAD, 32'h80000001, 0, 1, ST_OK, 0, 2);
    put_row(0, 0, 0,       REQ_READ_POS,  0,            1,   0, ST_OK, 0, 0);
    // Capacity lowered below the count: entries stay, pushes are refused.
    put_row(1, CAP_ADDR, 1,  REQ_PUSH_TAIL, 32'h9,      0,   1, ST_FULL, 0, 2);
    put_row(0, 0, 0,       REQ_POP_HEAD,  0,            0,   0, ST_OK, 0, 0);
    put_row(0, 0, 0,       REQ_PUSH_TAIL, 32'h10,       0,   1, ST_FULL, 0, 1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg) begin
        drain_results();
        write_config(directed_rows[i].cfg_addr, directed_rows[i].cfg_val);
      end
      offer_item(directed_rows[i].req, directed_rows[i].word, directed_rows[i].pos,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      cap = (phase_cap[ph] < 0) ? $urandom_range(0, 31) : phase_cap[ph];
      write_config(CAP_ADDR, PDATA_W'(cap));
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (k = 0; k < phase_items[ph]; k++) begin
        // Alternate push-heavy and pop-heavy stretches to reach full and empty.
        if (k % 40 == 0) filling = !filling;
        if (ph == PRESSURE_PHASE && k % 100 == 0) hold_request = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < (filling ? 70 : 20))
          r = ($urandom_range(0, 1) != 0) ? REQ_PUSH_HEAD : REQ_PUSH_TAIL;
        else if (pick < 85)
          r = REQ_POP_HEAD;
        else
          r = REQ_READ_POS;
        if ($urandom_range(0, 3) != 0) p = POS_W'($urandom_range(0, DEPTH + 1));
        else p = POS_W'($urandom);
        offer_item(r, $urandom, p, 1'b0, none);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("bounded_deque_engine test passed");
    end else begin
      $display("bounded_deque_engine test failed");
    end
    $finish;
  end

endmodule

// File: bounded_deque_engine.f
hw/rtl/bde_pkg.sv
hw/rtl/bde_ram.sv
hw/rtl/bde_front.sv
hw/rtl/bde_cmd_fifo.sv
hw/rtl/bde_back.sv
hw/rtl/bounded_deque_engine.sv
sim/bounded_deque_engine_test.sv
